// ===== rtl/core/mvn_pkg.sv =====
// Shared types and constants for the mesh vertex normal block.
// Used by the front, the back, the normalizer and the top level; depends on nothing.
package mvn_pkg;

  // Field widths fixed by the item formats.
  localparam int IDX_W   = 10;
  localparam int COORD_W = 16;
  localparam int NORM_W  = 16;
  localparam int SUM_W   = 28;

  // Internal datapath widths.
  localparam int EDGE_W  = COORD_W + 1;   // difference of two coordinates
  localparam int PROD_W  = 2 * EDGE_W;    // one cross-product term
  localparam int VEC_W   = 36;            // cross component or extended sum
  localparam int MAG_W   = 35;            // magnitude of a VEC_W value
  localparam int SQ_W    = 62;            // sum of three squares and root state
  localparam int LEN_W   = 31;            // vector length after normalizing
  localparam int DIV_W   = 45;            // divider remainder and divisor
  localparam int QUO_W   = 15;            // quotient, at most 2^14
  localparam int FRAC_SHIFT = 14;         // Q1.14 scale

  // Item actions as carried on tuser.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FACE  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Result kinds.
  typedef enum logic {
    KIND_FACE   = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_t;

  // One request as held in the queue between front and back.
  typedef struct packed {
    action_t                     act;
    logic [IDX_W-1:0]            idx_a;
    logic [IDX_W-1:0]            idx_b;
    logic [IDX_W-1:0]            idx_c;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic signed [COORD_W-1:0]   z;
  } item_t;

  // One result item.
  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    kind_t                    kind;
    logic                     degen;
  } result_t;

  // Normalizer response.
  typedef struct packed {
    logic                     done;
    logic                     degen;
    logic signed [NORM_W-1:0] qx;
    logic signed [NORM_W-1:0] qy;
    logic signed [NORM_W-1:0] qz;
  } norm_rsp_t;

  // Normalizer sequencer states.
  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIV_INIT,
    N_DIV,
    N_DONE
  } norm_state_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_FA,
    B_FB,
    B_FC,
    B_EDGE,
    B_CROSS,
    B_RRD,
    B_RCAP,
    B_NSTART,
    B_NWAIT,
    B_OUT,
    B_SRD,
    B_SWR
  } back_state_t;

endpackage

// ===== rtl/core/mvn_front.sv =====
// Front end: accepts requests, drops those with an index out of range, and queues the rest.
// Depends on mvn_pkg.
module mvn_front
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  hold,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  localparam int QDEPTH = 2;

  item_t      fifo [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       a_ok, b_ok, c_ok;
  logic       keep;
  logic       push;
  logic       pop;

  // Range checks on the indices that each action uses.
  assign a_ok = int'(in_item.idx_a) < MAX_VERTICES;
  assign b_ok = int'(in_item.idx_b) < MAX_VERTICES;
  assign c_ok = int'(in_item.idx_c) < MAX_VERTICES;

  always_comb begin
    case (in_item.act)
      ACT_CLEAR:          keep = 1'b1;
      ACT_LOAD, ACT_READ: keep = a_ok;
      ACT_FACE:           keep = a_ok & b_ok & c_ok;
      default:            keep = 1'b0;
    endcase
  end

  // The queue stops taking requests when full or while the sums are swept after reset.
  assign in_ready = (count != 2'(QDEPTH)) & ~hold;
  assign push     = in_valid & in_ready & keep;
  assign q_valid  = count != 2'd0;
  assign q_item   = fifo[rd_ptr];
  assign pop      = q_pop & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/core/mvn_norm.sv =====
// Normalizer: turns a signed 3-vector into a unit vector in Q1.14, one step per cycle.
// Holds a bit-serial square root and a restoring divider; depends on mvn_pkg.
module mvn_norm
  import mvn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] vx,
  input  logic signed [VEC_W-1:0] vy,
  input  logic signed [VEC_W-1:0] vz,
  output norm_rsp_t               rsp
);

  localparam logic [MAG_W-1:0] MAG_HI     = MAG_W'(1) << 29;
  localparam logic [MAG_W-1:0] MAG_LO     = MAG_W'(1) << 28;
  localparam logic [SQ_W-1:0]  ROOT_START = SQ_W'(1) << (SQ_W - 2);
  localparam int               SQ_IN_W    = PROD_W / 2 + 12;   // 29 bits after normalizing

  norm_state_t state, state_next;

  logic [MAG_W-1:0]           m [3];
  logic [2:0]                 neg;
  logic [MAG_W-1:0]           mx;
  logic [1:0]                 cnt;
  logic [2*SQ_IN_W-1:0]       sq_prod;
  logic [SQ_W-1:0]            ssum;
  logic [SQ_W-1:0]            root;
  logic [SQ_W-1:0]            rbit;
  logic [SQ_W-1:0]            trial;
  logic [LEN_W-1:0]           len;
  logic [DIV_W-1:0]           rem;
  logic [DIV_W-1:0]           den;
  logic [QUO_W-1:0]           quo;
  logic [QUO_W-1:0]           quo_next;
  logic                       ge;
  logic [3:0]                 step;
  logic [1:0]                 comp;
  logic [NORM_W-1:0]          qmag;
  logic [NORM_W-1:0]          qsig;
  logic                       degen;
  logic signed [NORM_W-1:0]   q [3];

  // Largest magnitude.
  always_comb begin
    mx = m[0];
    if (m[1] > mx) begin
      mx = m[1];
    end
    if (m[2] > mx) begin
      mx = m[2];
    end
  end

  assign len      = root[LEN_W-1:0];
  assign trial    = root + rbit;
  assign ge       = rem >= den;
  assign quo_next = {quo[QUO_W-2:0], ge};
  assign qmag     = {1'b0, quo_next};
  assign qsig     = neg[comp] ? (~qmag + NORM_W'(1)) : qmag;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and response.
  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.degen  = degen;
    rsp.qx     = q[0];
    rsp.qy     = q[1];
    rsp.qz     = q[2];
    case (state)
      N_IDLE: begin
        if (start) begin
          state_next = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (mx == '0) begin
          state_next = N_DONE;
        end else if (mx < MAG_HI && mx >= MAG_LO) begin
          state_next = N_SQUARE;
        end
      end
      N_SQUARE: begin
        if (cnt == 2'd3) begin
          state_next = N_ROOT;
        end
      end
      N_ROOT: begin
        if (rbit == SQ_W'(1)) begin
          state_next = N_DIV_INIT;
        end
      end
      N_DIV_INIT: begin
        state_next = N_DIV;
      end
      N_DIV: begin
        if (step == 4'(QUO_W - 1)) begin
          state_next = (comp == 2'd2) ? N_DONE : N_DIV_INIT;
        end
      end
      N_DONE: begin
        rsp.done   = 1'b1;
        state_next = N_IDLE;
      end
      default: begin
        state_next = N_IDLE;
      end
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        // Capture sign and magnitude of each component.
        neg   <= {vz[VEC_W-1], vy[VEC_W-1], vx[VEC_W-1]};
        m[0]  <= vx[VEC_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
        m[1]  <= vy[VEC_W-1] ? MAG_W'(-vy) : MAG_W'(vy);
        m[2]  <= vz[VEC_W-1] ? MAG_W'(-vz) : MAG_W'(vz);
        degen <= 1'b0;
        cnt   <= 2'd0;
        ssum  <= '0;
      end
      N_SHIFT: begin
        // Bring the largest magnitude into [2^28, 2^29).
        if (mx == '0) begin
          degen <= 1'b1;
          q[0]  <= '0;
          q[1]  <= '0;
          q[2]  <= '0;
        end else if (mx >= MAG_HI) begin
          m[0] <= m[0] >> 1;
          m[1] <= m[1] >> 1;
          m[2] <= m[2] >> 1;
        end else if (mx < MAG_LO) begin
          m[0] <= m[0] << 1;
          m[1] <= m[1] << 1;
          m[2] <= m[2] << 1;
        end
      end
      N_SQUARE: begin
        // One square per cycle, registered and then added to the sum.
        if (cnt != 2'd3) begin
          sq_prod <= m[cnt][SQ_IN_W-1:0] * m[cnt][SQ_IN_W-1:0];
        end
        if (cnt != 2'd0) begin
          ssum <= ssum + SQ_W'(sq_prod);
        end
        cnt  <= cnt + 2'd1;
        root <= '0;
        rbit <= ROOT_START;
      end
      N_ROOT: begin
        // Digit-by-digit integer square root.
        if (ssum >= trial) begin
          ssum <= ssum - trial;
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        comp <= 2'd0;
      end
      N_DIV_INIT: begin
        // Rounded numerator m * 2^14 + len / 2.
        rem  <= (DIV_W'(m[comp]) << FRAC_SHIFT) + DIV_W'(len >> 1);
        den  <= DIV_W'(len) << FRAC_SHIFT;
        quo  <= '0;
        step <= 4'd0;
      end
      N_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (ge) begin
          rem <= rem - den;
        end
        quo  <= quo_next;
        den  <= den >> 1;
        step <= step + 4'd1;
        if (step == 4'(QUO_W - 1)) begin
          q[comp] <= qsig;
          comp    <= comp + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/mvn_back.sv =====
// Back end: vertex store, normal sums, cross product, sum updates and the output register.
// Instantiates mvn_norm; depends on mvn_pkg.
module mvn_back
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    hold,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int DEPTH = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(1 << (SUM_W - 1));

  back_state_t state, state_next;

  logic [3*COORD_W-1:0] vmem [DEPTH];
  logic [3*SUM_W-1:0]   smem [DEPTH];
  logic [3*COORD_W-1:0] vrd;
  logic [3*SUM_W-1:0]   srd;
  logic [AW-1:0]        vaddr;
  logic [AW-1:0]        saddr;
  logic                 swe;
  logic [3*SUM_W-1:0]   swdata;

  item_t                     cur;
  logic                      init_busy;
  logic [AW-1:0]             clr_cnt;
  logic [3*COORD_W-1:0]      va, vb;
  logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [EDGE_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0]  prod;
  logic [2:0]                cnt;
  logic signed [VEC_W-1:0]   acc [3];
  logic [1:0]                corner;
  logic                      nstart;
  norm_rsp_t                 nrsp;
  logic signed [NORM_W-1:0]  qn [3];
  logic                      qdeg;
  logic                      out_load;
  logic signed [SUM_W:0]     wide [3];
  logic signed [SUM_W-1:0]   satv [3];

  assign hold = init_busy;

  // Coordinate difference of two stored vertices, one component.
  function automatic logic signed [EDGE_W-1:0] sub_c(input logic [COORD_W-1:0] p,
                                                     input logic [COORD_W-1:0] r);
    sub_c = $signed({p[COORD_W-1], p}) - $signed({r[COORD_W-1], r});
  endfunction

  // Sum addresses: the three corners, the clear sweep and the vertex read.
  always_comb begin
    case (corner)
      2'd0:    saddr = AW'(cur.idx_a);
      2'd1:    saddr = AW'(cur.idx_b);
      default: saddr = AW'(cur.idx_c);
    endcase
    if (state == B_CLEAR) begin
      saddr = clr_cnt;
    end else if (state == B_RRD) begin
      saddr = AW'(cur.idx_a);
    end
  end

  always_comb begin
    case (state)
      B_FB:    vaddr = AW'(cur.idx_b);
      B_FC:    vaddr = AW'(cur.idx_c);
      default: vaddr = AW'(cur.idx_a);
    endcase
  end

  // Saturating add of the face normal to a stored sum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = $signed({srd[i*SUM_W + SUM_W - 1], srd[i*SUM_W +: SUM_W]}) +
                (SUM_W + 1)'(qn[i]);
      if (wide[i] > SUM_MAX) begin
        satv[i] = SUM_MAX[SUM_W-1:0];
      end else if (wide[i] < SUM_MIN) begin
        satv[i] = SUM_MIN[SUM_W-1:0];
      end else begin
        satv[i] = wide[i][SUM_W-1:0];
      end
    end
  end

  assign swe    = (state == B_CLEAR) || (state == B_SWR);
  assign swdata = (state == B_CLEAR) ? '0 : {satv[2], satv[1], satv[0]};

  // Vertex store: written by load requests, read one corner per cycle.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid && q_item.act == ACT_LOAD) begin
      vmem[AW'(q_item.idx_a)] <= {q_item.z, q_item.y, q_item.x};
    end
    vrd <= vmem[vaddr];
  end

  // Sum store: one read-modify-write per corner, cleared by a sweep.
  always_ff @(posedge clk) begin
    if (swe) begin
      smem[saddr] <= swdata;
    end
    srd <= smem[saddr];
  end

  // Cross-product operand select, one term per cycle.
  always_comb begin
    case (cnt)
      3'd0:    begin opa = e1y; opb = e2z; end
      3'd1:    begin opa = e1z; opb = e2y; end
      3'd2:    begin opa = e1z; opb = e2x; end
      3'd3:    begin opa = e1x; opb = e2z; end
      3'd4:    begin opa = e1x; opb = e2y; end
      default: begin opa = e1y; opb = e2x; end
    endcase
  end

  mvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .vx    (acc[0]),
    .vy    (acc[1]),
    .vz    (acc[2]),
    .rsp   (nrsp)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    nstart     = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.act)
            ACT_CLEAR: state_next = B_CLEAR;
            ACT_FACE:  state_next = B_FA;
            ACT_READ:  state_next = B_RRD;
            default:   state_next = B_IDLE;
          endcase
        end
      end
      B_FA:     state_next = B_FB;
      B_FB:     state_next = B_FC;
      B_FC:     state_next = B_EDGE;
      B_EDGE:   state_next = B_CROSS;
      B_CROSS: begin
        if (cnt == 3'd6) begin
          state_next = B_NSTART;
        end
      end
      B_RRD:    state_next = B_RCAP;
      B_RCAP:   state_next = B_NSTART;
      B_NSTART: begin
        nstart     = 1'b1;
        state_next = B_NWAIT;
      end
      B_NWAIT: begin
        if (nrsp.done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid) begin
          out_load   = 1'b1;
          state_next = (cur.act == ACT_FACE) ? B_SRD : B_IDLE;
        end
      end
      B_SRD:    state_next = B_SWR;
      B_SWR: begin
        state_next = (corner == 2'd2) ? B_IDLE : B_SRD;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          init_busy <= 1'b0;
          clr_cnt   <= '0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur    <= q_item;
        corner <= 2'd0;
      end
      B_FB: va <= vrd;
      B_FC: vb <= vrd;
      B_EDGE: begin
        // Edges from the first corner.
        e1x    <= sub_c(vb[0*COORD_W +: COORD_W], va[0*COORD_W +: COORD_W]);
        e1y    <= sub_c(vb[1*COORD_W +: COORD_W], va[1*COORD_W +: COORD_W]);
        e1z    <= sub_c(vb[2*COORD_W +: COORD_W], va[2*COORD_W +: COORD_W]);
        e2x    <= sub_c(vrd[0*COORD_W +: COORD_W], va[0*COORD_W +: COORD_W]);
        e2y    <= sub_c(vrd[1*COORD_W +: COORD_W], va[1*COORD_W +: COORD_W]);
        e2z    <= sub_c(vrd[2*COORD_W +: COORD_W], va[2*COORD_W +: COORD_W]);
        cnt    <= 3'd0;
        acc[0] <= '0;
        acc[1] <= '0;
        acc[2] <= '0;
      end
      B_CROSS: begin
        // Multiply one term, then fold it into its component next cycle.
        prod <= opa * opb;
        cnt  <= cnt + 3'd1;
        case (cnt)
          3'd1: acc[0] <= acc[0] + VEC_W'(prod);
          3'd2: acc[0] <= acc[0] - VEC_W'(prod);
          3'd3: acc[1] <= acc[1] + VEC_W'(prod);
          3'd4: acc[1] <= acc[1] - VEC_W'(prod);
          3'd5: acc[2] <= acc[2] + VEC_W'(prod);
          3'd6: acc[2] <= acc[2] - VEC_W'(prod);
          default: begin
          end
        endcase
      end
      B_RCAP: begin
        acc[0] <= VEC_W'($signed(srd[0*SUM_W +: SUM_W]));
        acc[1] <= VEC_W'($signed(srd[1*SUM_W +: SUM_W]));
        acc[2] <= VEC_W'($signed(srd[2*SUM_W +: SUM_W]));
      end
      B_NWAIT: begin
        if (nrsp.done) begin
          qn[0] <= nrsp.qx;
          qn[1] <= nrsp.qy;
          qn[2] <= nrsp.qz;
          qdeg  <= nrsp.degen;
        end
      end
      B_SWR: corner <= corner + 2'd1;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.nx    <= qn[0];
      out_data.ny    <= qn[1];
      out_data.nz    <= qn[2];
      out_data.kind  <= (cur.act == ACT_FACE) ? KIND_FACE : KIND_VERTEX;
      out_data.degen <= qdeg;
    end
  end

endmodule

// ===== rtl/core/mesh_vertex_normals.sv =====
// Top level of the mesh vertex normal block: stream ports and the front/back split.
// Instantiates mvn_front and mvn_back; depends on mvn_pkg.
//
// Requests arrive on the s_axis channel; tuser carries the action (clear sums, load
// vertex, add face, read vertex normal). Add face and read each give one result on
// m_axis: a unit normal in Q1.14 with its kind and a degenerate flag. Clear and load
// give none, and a request with an index of MAX_VERTICES or more is taken and dropped.
// The front takes requests into a two-entry queue; the back works one at a time.
// Load is a single vertex store write in the back and clear a sweep over the sum
// memory. Face and read are bound by the normalizer: a shift of one bit per cycle,
// three squares and their sum, a 31-step square root, a division of 15 quotient bits
// per component and a done state, plus memory reads and cross product for a face or
// a sum read for a read, an output state, and a read and a write of the sum for each
// corner of a face.
// After reset the back sweeps the sum memory to zero and s_axis_tready stays low
// meanwhile. A result waits in an output register while the receiver stalls; the
// queue keeps taking requests until full.
module mesh_vertex_normals
  import mvn_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // vertex_index, coord_x, coord_y, coord_z, corner_b,
                                      // corner_c, zero fill
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // normal_x, normal_y, normal_z
  output logic [1:0]  m_axis_tuser    // normal_kind, degenerate
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  logic    hold;
  result_t res;

  // Unpack the request.
  assign in_item.act   = action_t'(s_axis_tuser);
  assign in_item.idx_a = s_axis_tdata[9:0];
  assign in_item.x     = s_axis_tdata[25:10];
  assign in_item.y     = s_axis_tdata[41:26];
  assign in_item.z     = s_axis_tdata[57:42];
  assign in_item.idx_b = s_axis_tdata[67:58];
  assign in_item.idx_c = s_axis_tdata[77:68];

  mvn_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .hold     (hold),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mvn_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .hold      (hold),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  // Pack the result.
  assign m_axis_tdata = {res.nz, res.ny, res.nx};
  assign m_axis_tuser = {res.degen, res.kind};

endmodule

// ===== rtl/core/mvn_checker.sv =====
// Port-level checks for the mesh vertex normal block, bound to the top level.
// Depends on nothing beyond the top level's ports.
module mvn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Right after reset the sum sweep keeps the input closed and no result is shown.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("block active right after reset");

  // A degenerate result carries a zero normal.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 48'd0)
    else $error("degenerate result with nonzero normal");

  // Every component stays within one in Q1.14.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0])  <= 16'sd16384 && $signed(m_axis_tdata[15:0])  >= -16'sd16384)
   && ($signed(m_axis_tdata[31:16]) <= 16'sd16384 && $signed(m_axis_tdata[31:16]) >= -16'sd16384)
   && ($signed(m_axis_tdata[47:32]) <= 16'sd16384 && $signed(m_axis_tdata[47:32]) >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind mesh_vertex_normals mvn_checker u_mvn_checker (.*);

// ===== dv/mesh_vertex_normals_tb.sv =====
// Self-checking testbench for mesh_vertex_normals: face and vertex normal requests.
// Predicts every result in SystemVerilog and checks the m_axis stream; needs mvn_pkg.
`timescale 1ns / 100ps

module mesh_vertex_normals_tb;
  import mvn_pkg::*;

  localparam int NVERT       = 1024;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 1300;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint SUM_HI  = 134217727;
  localparam longint SUM_LO  = -134217728;

  // Expected normal as it appears on the result stream.
  typedef struct {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    kind_t                    kind;
    logic                     degen;
  } normal_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // vertex_index, coord_x, coord_y, coord_z, corner_b,
                                    // corner_c, zero fill
  logic [1:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // normal_x, normal_y, normal_z
  logic [1:0]  m_axis_tuser;        // normal_kind, degenerate

  mesh_vertex_normals u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Shadow copy of the vertex store and the normal sums.
  longint    vert_x [NVERT];
  longint    vert_y [NVERT];
  longint    vert_z [NVERT];
  longint    acc_x  [NVERT];
  longint    acc_y  [NVERT];
  longint    acc_z  [NVERT];
  bit        is_loaded [NVERT];
  bit [9:0]  loaded_list[$];
  normal_t   pending_normals[$];

  int        mismatch_cnt = 0;
  longint    cycle_cnt = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;
  logic      holding = 1'b0;
  int        rdy_mode = 0;
  int        rdy_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a vector to unit length in Q1.14 with the block's fixed-point rules.
  function automatic normal_t unit_normal(input longint cx, input longint cy,
                                          input longint cz, input kind_t k);
    longint          comp [3];
    longint unsigned mag  [3];
    bit              neg  [3];
    longint unsigned mx, sq, len, u;
    longint          q;
    normal_t         r;
    int              i;
    comp[0] = cx; comp[1] = cy; comp[2] = cz;
    mx = 0;
    for (i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    r.kind = k;
    r.nx = '0; r.ny = '0; r.nz = '0;
    if (mx == 0) begin
      r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;
    while (mx >= (64'd1 << 29)) begin
      for (i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 28)) begin
      for (i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      mx = mx << 1;
    end
    sq = 0;
    for (i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = int_sqrt(sq);
    for (i = 0; i < 3; i++) begin
      u = (mag[i] * 16384 + len / 2) / len;
      q = neg[i] ? -longint'(u) : longint'(u);
      if (i == 0) r.nx = q[15:0];
      else if (i == 1) r.ny = q[15:0];
      else r.nz = q[15:0];
    end
    return r;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    return s;
  endfunction

  // Update the shadow state for one accepted request and queue its normal, if any.
  task automatic predict_request(input action_t act, input bit [9:0] a,
                                 input logic signed [15:0] x, input logic signed [15:0] y,
                                 input logic signed [15:0] z, input bit [9:0] b,
                                 input bit [9:0] c);
    longint  e1x, e1y, e1z, e2x, e2y, e2z;
    normal_t n;
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < NVERT; i++) begin
          acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
        end
      end
      ACT_LOAD: begin
        vert_x[a] = x; vert_y[a] = y; vert_z[a] = z;
        if (!is_loaded[a]) begin
          is_loaded[a] = 1'b1;
          loaded_list.push_back(a);
        end
      end
      ACT_READ: begin
        pending_normals.push_back(unit_normal(acc_x[a], acc_y[a], acc_z[a], KIND_VERTEX));
      end
      default: begin
        e1x = vert_x[b] - vert_x[a]; e1y = vert_y[b] - vert_y[a]; e1z = vert_z[b] - vert_z[a];
        e2x = vert_x[c] - vert_x[a]; e2y = vert_y[c] - vert_y[a]; e2z = vert_z[c] - vert_z[a];
        n = unit_normal(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                        e1x * e2y - e1y * e2x, KIND_FACE);
        // Each corner takes the normal, so a repeated corner takes it twice.
        acc_x[a] = sat_sum(acc_x[a], longint'(n.nx));
        acc_y[a] = sat_sum(acc_y[a], longint'(n.ny));
        acc_z[a] = sat_sum(acc_z[a], longint'(n.nz));
        acc_x[b] = sat_sum(acc_x[b], longint'(n.nx));
        acc_y[b] = sat_sum(acc_y[b], longint'(n.ny));
        acc_z[b] = sat_sum(acc_z[b], longint'(n.nz));
        acc_x[c] = sat_sum(acc_x[c], longint'(n.nx));
        acc_y[c] = sat_sum(acc_y[c], longint'(n.ny));
        acc_z[c] = sat_sum(acc_z[c], longint'(n.nz));
        pending_normals.push_back(n);
      end
    endcase
  endtask

  // Offer one request, with a random gap between bursts, and wait for it to be taken.
  task automatic send_item(input action_t act, input bit [9:0] a,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z, input bit [9:0] b,
                           input bit [9:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, c, b, z, y, x, a};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(act, a, x, y, z, b, c);
  endtask

  task automatic load_vertex(input bit [9:0] a, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
    send_item(ACT_LOAD, a, x, y, z, 10'($urandom), 10'($urandom));
  endtask

  task automatic add_face(input bit [9:0] a, input bit [9:0] b, input bit [9:0] c);
    send_item(ACT_FACE, a, 16'($urandom), 16'($urandom), 16'($urandom), b, c);
  endtask

  task automatic read_normal(input bit [9:0] a);
    send_item(ACT_READ, a, 16'($urandom), 16'($urandom), 16'($urandom),
              10'($urandom), 10'($urandom));
  endtask

  task automatic send_clear();
    send_item(ACT_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              10'($urandom), 10'($urandom));
  endtask

  function automatic bit [9:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 127)) - 16'sd64;
    return 16'($urandom);
  endfunction

  // Extreme coordinates, extreme indices and the large cross products they give.
  task automatic test_extremes();
    load_vertex(10'd0,    16'sh7fff, 16'sh7fff, 16'sh7fff);
    load_vertex(10'd1023, -16'sh8000, -16'sh8000, -16'sh8000);
    load_vertex(10'd1,    16'sd0, 16'sd0, 16'sd0);
    load_vertex(10'd2,    16'sh7fff, -16'sh8000, 16'sd0);
    load_vertex(10'd3,    -16'sh8000, 16'sd0, 16'sh7fff);
    load_vertex(10'd682,  16'sd1, 16'sd0, 16'sd0);
    load_vertex(10'd341,  16'sd0, 16'sd1, 16'sd0);
    add_face(10'd1023, 10'd2, 10'd3);
    add_face(10'd1, 10'd682, 10'd341);
    add_face(10'd0, 10'd3, 10'd2);
    read_normal(10'd1023);
    read_normal(10'd1);
  endtask

  // Degenerate faces and vertices whose sum is zero.
  task automatic test_degenerate();
    add_face(10'd2, 10'd2, 10'd3);      // repeated corner
    add_face(10'd1023, 10'd1, 10'd0);   // three collinear corners
    add_face(10'd3, 10'd3, 10'd3);
    read_normal(10'd500);               // never touched by a face
    add_face(10'd341, 10'd682, 10'd1);  // cancels the earlier unit face at these corners
    read_normal(10'd682);
  endtask

  // A clear request zeroes every sum.
  task automatic test_clear();
    send_clear();
    read_normal(10'd2);
    add_face(10'd0, 10'd2, 10'd3);
    read_normal(10'd3);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) add_face(pick_loaded(), pick_loaded(), pick_loaded());
    read_normal(pick_loaded());
    s_axis_tvalid <= 1'b0;
    wait (!hold_req);
  endtask

  // Mostly meshes built on loaded vertices, with loads, reads and rare clears.
  task automatic test_random(input int count);
    int sel;
    bit [9:0] a, b, c;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_clear();
      end else if (sel < 26) begin
        load_vertex(10'($urandom), rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 36) begin
        // Fresh triangle on three new positions.
        a = 10'($urandom); b = 10'($urandom); c = 10'($urandom);
        load_vertex(a, rand_coord(), rand_coord(), rand_coord());
        load_vertex(b, rand_coord(), rand_coord(), rand_coord());
        load_vertex(c, rand_coord(), rand_coord(), rand_coord());
        add_face(a, b, c);
        read_normal(a);
        n += 4;
      end else if (sel < 75) begin
        a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
        if ($urandom_range(0, 19) == 0) b = a;
        add_face(a, b, c);
      end else if (sel < 90) begin
        read_normal(pick_loaded());
      end else begin
        read_normal(10'($urandom));
      end
    end
  endtask

  // Long hold-off of the receiver, counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Receiver stall pattern: stretches of always-ready, half-ready and mostly-ready.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(20, 300);
    end
    rdy_left--;
    if (holding) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rdy_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expected normal.
  always @(posedge clk) begin
    normal_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_normals.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_normals.pop_front();
        if (m_axis_tdata[15:0] !== want.nx || m_axis_tdata[31:16] !== want.ny ||
            m_axis_tdata[47:32] !== want.nz || m_axis_tuser[0] !== want.kind ||
            m_axis_tuser[1] !== want.degen) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected n=(%0d,%0d,%0d) kind=%0d degen=%0d, got n=(%0d,%0d,%0d) kind=%0d degen=%0d",
                     want.nx, want.ny, want.nz, want.kind, want.degen,
                     $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                     $signed(m_axis_tdata[47:32]), m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("mesh_vertex_normals test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NVERT; i++) begin
      vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      is_loaded[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_degenerate();
    test_clear();
    test_random(400);
    test_backpressure();
    test_random(400);
    s_axis_tvalid <= 1'b0;
    wait (pending_normals.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && pending_normals.size() == 0) begin
      $display("mesh_vertex_normals test passed");
    end else begin
      $display("mesh_vertex_normals test failed");
    end
    $finish;
  end

endmodule
